/* sv/esc_pkg.sv */
// shared types, constants and microprogram for the epoch-to-calendar converter
package esc_pkg;

  localparam int unsigned PC_W = 4;
  typedef logic [PC_W-1:0] pc_t;

  // datapath operations selected by the control word
  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_DAY_Q,
    OP_HOUR_Q,
    OP_MIN_Q,
    OP_WDAY_Q,
    OP_REM,
    OP_YEAR_SETUP,
    OP_YEAR,
    OP_MONTH,
    OP_WRITE
  } op_t;

  // jump conditions
  typedef enum logic [2:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_NO_INPUT,
    COND_LEN_GE,
    COND_OUT_FREE
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    pc_t   tgt;
  } ctrl_t;

  typedef struct packed {
    logic in_avail;
    logic len_ge;
    logic out_free;
  } stat_t;

  // program addresses
  localparam pc_t PC_IDLE     = 4'd0;
  localparam pc_t PC_DAY_Q    = 4'd1;
  localparam pc_t PC_DAY_R    = 4'd2;
  localparam pc_t PC_HOUR_Q   = 4'd3;
  localparam pc_t PC_HOUR_R   = 4'd4;
  localparam pc_t PC_MIN_Q    = 4'd5;
  localparam pc_t PC_MIN_R    = 4'd6;
  localparam pc_t PC_WDAY_Q   = 4'd7;
  localparam pc_t PC_WDAY_R   = 4'd8;
  localparam pc_t PC_YEAR_SET = 4'd9;
  localparam pc_t PC_YEAR     = 4'd10;
  localparam pc_t PC_MONTH    = 4'd11;
  localparam pc_t PC_WRITE    = 4'd12;
  localparam pc_t PC_HOLD     = 4'd13;
  localparam pc_t PC_LAST     = PC_HOLD;

  // datapath widths
  localparam int unsigned ACC_W = 32;
  localparam int unsigned QUO_W = 16;
  localparam int unsigned DVS_W = 17;

  localparam int unsigned SECS_PER_MIN  = 60;
  localparam int unsigned SECS_PER_HOUR = 3600;
  localparam int unsigned SECS_PER_DAY  = 86400;
  localparam int unsigned DAYS_PER_WEEK = 7;
  localparam int unsigned EPOCH_WDAY    = 4;   // 1970-01-01 was a thursday
  localparam int unsigned BASE_YEAR     = 1970;
  localparam int unsigned DAYS_COMMON   = 365;
  localparam int unsigned LAST_MONTH    = 11;

  // reciprocal division: q = ((x >> PRE) * MAG) >> SH, exact over each operand range
  // day: (t >> 7) / 675, t below 2^32
  localparam int unsigned DAY_PRE  = 7;
  localparam int unsigned DAY_MAG  = 50903317;
  localparam int unsigned DAY_SH   = 35;
  // hour: (r >> 4) / 225, r below 86400
  localparam int unsigned HOUR_PRE = 4;
  localparam int unsigned HOUR_MAG = 9321;
  localparam int unsigned HOUR_SH  = 21;
  // minute: (r >> 2) / 15, r below 3600
  localparam int unsigned MIN_PRE  = 2;
  localparam int unsigned MIN_MAG  = 1093;
  localparam int unsigned MIN_SH   = 14;
  // weekday: x / 7, x below 2^16
  localparam int unsigned WDAY_MAG = 74899;
  localparam int unsigned WDAY_SH  = 19;

  localparam logic [3:0] MON_FEB = 4'd1;
  localparam logic [4:0] MON_LEN_TBL [12] = '{5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
                                              5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31};

  // the only century years reachable are 2000 (leap) and 2100 (common)
  localparam logic [11:0] NONLEAP_CENTURY = 12'd2100;

  function automatic logic leap_year(input logic [11:0] y);
    return (y[1:0] == 2'b00) && (y != NONLEAP_CENTURY);
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    return (m == MON_FEB && leap) ? 5'd29 : MON_LEN_TBL[m];
  endfunction

  function automatic ctrl_t ucode(input pc_t pc);
    ctrl_t w;
    w = '{op: OP_NOP, cond: COND_ALWAYS, tgt: PC_IDLE};
    case (pc)
      PC_IDLE:     w = '{op: OP_LOAD,       cond: COND_NO_INPUT, tgt: PC_IDLE};
      PC_DAY_Q:    w = '{op: OP_DAY_Q,      cond: COND_NEVER,    tgt: PC_IDLE};
      PC_DAY_R:    w = '{op: OP_REM,        cond: COND_NEVER,    tgt: PC_IDLE};
      PC_HOUR_Q:   w = '{op: OP_HOUR_Q,     cond: COND_NEVER,    tgt: PC_IDLE};
      PC_HOUR_R:   w = '{op: OP_REM,        cond: COND_NEVER,    tgt: PC_IDLE};
      PC_MIN_Q:    w = '{op: OP_MIN_Q,      cond: COND_NEVER,    tgt: PC_IDLE};
      PC_MIN_R:    w = '{op: OP_REM,        cond: COND_NEVER,    tgt: PC_IDLE};
      PC_WDAY_Q:   w = '{op: OP_WDAY_Q,     cond: COND_NEVER,    tgt: PC_IDLE};
      PC_WDAY_R:   w = '{op: OP_REM,        cond: COND_NEVER,    tgt: PC_IDLE};
      PC_YEAR_SET: w = '{op: OP_YEAR_SETUP, cond: COND_NEVER,    tgt: PC_IDLE};
      PC_YEAR:     w = '{op: OP_YEAR,       cond: COND_LEN_GE,   tgt: PC_YEAR};
      PC_MONTH:    w = '{op: OP_MONTH,      cond: COND_LEN_GE,   tgt: PC_MONTH};
      PC_WRITE:    w = '{op: OP_WRITE,      cond: COND_OUT_FREE, tgt: PC_IDLE};
      PC_HOLD:     w = '{op: OP_NOP,        cond: COND_ALWAYS,   tgt: PC_WRITE};
      default:     w = '{op: OP_NOP,        cond: COND_ALWAYS,   tgt: PC_IDLE};
    endcase
    return w;
  endfunction

endpackage

/* sv/esc_useq.sv */
// microprogram sequencer: step counter, control store and jump logic
module esc_useq (
  input  logic           clk,
  input  logic           rst_n,
  input  esc_pkg::stat_t stat,
  output esc_pkg::ctrl_t ctrl
);
  import esc_pkg::*;

  pc_t  pc_r;
  pc_t  pc_nxt;
  logic take;

  assign ctrl = ucode(pc_r);

  always_comb begin
    case (ctrl.cond)
      COND_NEVER:    take = 1'b0;
      COND_ALWAYS:   take = 1'b1;
      COND_NO_INPUT: take = !stat.in_avail;
      COND_LEN_GE:   take = stat.len_ge;
      COND_OUT_FREE: take = stat.out_free;
      default:       take = 1'b1;
    endcase
  end

  assign pc_nxt = take ? ctrl.tgt : pc_t'(pc_r + 1'b1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= PC_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  a_load_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
    (pc_r == PC_IDLE && stat.in_avail) |=> (pc_r == PC_DAY_Q))
    else $error("accepted timestamp did not start the day division");

  a_pc_in_program: assert property (@(posedge clk) disable iff (!rst_n)
    pc_r <= PC_LAST)
    else $error("step counter left the program");

  a_hold_returns: assert property (@(posedge clk) disable iff (!rst_n)
    (pc_r == PC_HOLD) |=> (pc_r == PC_WRITE))
    else $error("held result did not retry the write");

endmodule

/* sv/esc_dpath.sv */
// datapath: reciprocal-multiply divider, year and month walk, result register
module esc_dpath (
  input  logic           clk,
  input  logic           rst_n,
  input  esc_pkg::ctrl_t ctrl,
  output esc_pkg::stat_t stat,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [31:0]    in_epoch_seconds,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [5:0]     out_second,
  output logic [5:0]     out_minute,
  output logic [4:0]     out_hour,
  output logic [4:0]     out_day_of_month,
  output logic [3:0]     out_month,
  output logic [11:0]    out_year,
  output logic [2:0]     out_weekday
);
  import esc_pkg::*;

  logic [ACC_W-1:0] acc_r, acc_nxt;
  logic [DVS_W-1:0] dvs_r, dvs_nxt;
  logic [QUO_W-1:0] quo_r, quo_nxt;
  logic [QUO_W-1:0] days_r, days_nxt;
  logic [11:0]      year_r, year_nxt;
  logic [3:0]       mon_r, mon_nxt;
  logic [4:0]       hour_r, hour_nxt;
  logic [5:0]       min_r, min_nxt;
  logic [5:0]       sec_r, sec_nxt;
  logic [2:0]       wday_r, wday_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [5:0]  o_sec_r, o_min_r;
  logic [4:0]  o_hour_r, o_day_r;
  logic [3:0]  o_mon_r;
  logic [11:0] o_year_r;
  logic [2:0]  o_wday_r;

  // reciprocal products, sized to hold each operand range without overflow
  logic [50:0]      day_prod;
  logic [26:0]      hour_prod;
  logic [20:0]      min_prod;
  logic [32:0]      wday_prod;
  logic [QUO_W-1:0] wday_x;
  logic [ACC_W:0]   rem_prod;

  logic       leap;
  logic [8:0] ylen;
  logic [4:0] mlen;
  logic       year_ge;
  logic       month_ge;
  logic       out_free;
  logic       wr_fire;

  assign day_prod  = 51'(acc_r[ACC_W-1:DAY_PRE]) * 51'(DAY_MAG);
  assign hour_prod = 27'(acc_r[16:HOUR_PRE]) * 27'(HOUR_MAG);
  assign min_prod  = 21'(acc_r[11:MIN_PRE]) * 21'(MIN_MAG);
  assign wday_x    = days_r + QUO_W'(EPOCH_WDAY);
  assign wday_prod = 33'(wday_x) * 33'(WDAY_MAG);
  assign rem_prod  = 33'(quo_r) * 33'(dvs_r);

  assign leap     = leap_year(year_r);
  assign ylen     = 9'(DAYS_COMMON) + {8'd0, leap};
  assign mlen     = month_len(mon_r, leap);
  assign year_ge  = acc_r >= ACC_W'(ylen);
  assign month_ge = (mon_r < 4'(LAST_MONTH)) && (acc_r >= ACC_W'(mlen));
  assign out_free = !out_valid_r || out_ready;
  assign wr_fire  = (ctrl.op == OP_WRITE) && out_free;
  assign in_ready = (ctrl.op == OP_LOAD);

  always_comb begin
    stat.in_avail = in_valid;
    stat.out_free = out_free;
    case (ctrl.op)
      OP_YEAR:  stat.len_ge = year_ge;
      OP_MONTH: stat.len_ge = month_ge;
      default:  stat.len_ge = 1'b0;
    endcase
  end

  always_comb begin
    acc_nxt  = acc_r;
    dvs_nxt  = dvs_r;
    quo_nxt  = quo_r;
    days_nxt = days_r;
    year_nxt = year_r;
    mon_nxt  = mon_r;
    hour_nxt = hour_r;
    min_nxt  = min_r;
    sec_nxt  = sec_r;
    wday_nxt = wday_r;
    case (ctrl.op)
      OP_LOAD: begin
        if (in_valid) begin
          acc_nxt = in_epoch_seconds;
        end
      end
      OP_DAY_Q: begin
        quo_nxt = day_prod[DAY_SH +: QUO_W];
        dvs_nxt = DVS_W'(SECS_PER_DAY);
      end
      OP_HOUR_Q: begin
        days_nxt = quo_r;
        quo_nxt  = QUO_W'(hour_prod[26:HOUR_SH]);
        dvs_nxt  = DVS_W'(SECS_PER_HOUR);
      end
      OP_MIN_Q: begin
        hour_nxt = quo_r[4:0];
        quo_nxt  = QUO_W'(min_prod[20:MIN_SH]);
        dvs_nxt  = DVS_W'(SECS_PER_MIN);
      end
      OP_WDAY_Q: begin
        min_nxt = quo_r[5:0];
        sec_nxt = acc_r[5:0];
        acc_nxt = ACC_W'(wday_x);
        quo_nxt = QUO_W'(wday_prod[32:WDAY_SH]);
        dvs_nxt = DVS_W'(DAYS_PER_WEEK);
      end
      OP_REM: begin
        // remainder of the quotient found in the previous step
        acc_nxt = acc_r - rem_prod[ACC_W-1:0];
      end
      OP_YEAR_SETUP: begin
        wday_nxt = acc_r[2:0] + 3'd1;
        acc_nxt  = ACC_W'(days_r);
        year_nxt = 12'(BASE_YEAR);
        mon_nxt  = '0;
      end
      OP_YEAR: begin
        if (year_ge) begin
          acc_nxt  = acc_r - ACC_W'(ylen);
          year_nxt = year_r + 12'd1;
        end
      end
      OP_MONTH: begin
        if (month_ge) begin
          acc_nxt = acc_r - ACC_W'(mlen);
          mon_nxt = mon_r + 4'd1;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (wr_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r  <= acc_nxt;
    dvs_r  <= dvs_nxt;
    quo_r  <= quo_nxt;
    days_r <= days_nxt;
    year_r <= year_nxt;
    mon_r  <= mon_nxt;
    hour_r <= hour_nxt;
    min_r  <= min_nxt;
    sec_r  <= sec_nxt;
    wday_r <= wday_nxt;
    if (wr_fire) begin
      o_sec_r  <= sec_r;
      o_min_r  <= min_r;
      o_hour_r <= hour_r;
      o_day_r  <= acc_r[4:0] + 5'd1;
      o_mon_r  <= mon_r + 4'd1;
      o_year_r <= year_r;
      o_wday_r <= wday_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_second       = o_sec_r;
  assign out_minute       = o_min_r;
  assign out_hour         = o_hour_r;
  assign out_day_of_month = o_day_r;
  assign out_month        = o_mon_r;
  assign out_year         = o_year_r;
  assign out_weekday      = o_wday_r;

  a_day_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.op == OP_HOUR_Q) |-> (acc_r < ACC_W'(SECS_PER_DAY)))
    else $error("time of day remainder out of range");

  a_month_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.op == OP_MONTH) |-> (mon_r <= 4'(LAST_MONTH)))
    else $error("month walk ran past december");

  a_year_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.op == OP_YEAR) |-> (year_r <= 12'd2106))
    else $error("year walk ran past the 32-bit range");

  a_write_lands: assert property (@(posedge clk) disable iff (!rst_n)
    wr_fire |=> (out_valid_r && out_year == $past(year_r)))
    else $error("result transfer not registered");

endmodule

/* sv/epoch_seconds_to_calendar_unit.sv */
// top level: converts unix seconds to utc calendar date, time and weekday
// the result follows four reciprocal-multiply divisions (quotient and remainder step each),
// a one-year / one-month-per-cycle walk over Y = years past 1970 (0..136) and M =
// zero-based month (0..11), and the write, which waits while the result stalls; a new
// timestamp is taken only in idle, once the previous result has been written out
// reset: synchronous active-low rst_n returns the sequencer to idle and empties the output
module epoch_seconds_to_calendar_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_epoch_seconds,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [5:0]  out_second,
  output logic [5:0]  out_minute,
  output logic [4:0]  out_hour,
  output logic [4:0]  out_day_of_month,
  output logic [3:0]  out_month,
  output logic [11:0] out_year,
  output logic [2:0]  out_weekday
);
  import esc_pkg::*;

  ctrl_t ctrl;
  stat_t stat;

  esc_useq u_useq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .ctrl  (ctrl)
  );

  esc_dpath u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .ctrl             (ctrl),
    .stat             (stat),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_epoch_seconds (in_epoch_seconds),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_second       (out_second),
    .out_minute       (out_minute),
    .out_hour         (out_hour),
    .out_day_of_month (out_day_of_month),
    .out_month        (out_month),
    .out_year         (out_year),
    .out_weekday      (out_weekday)
  );

endmodule

/* sim/esc_checker.sv */
// checker for the epoch-to-calendar unit: predicts each date and compares the results
module esc_checker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [31:0]       in_epoch_seconds,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic [5:0]        out_second,
  input  logic [5:0]        out_minute,
  input  logic [4:0]        out_hour,
  input  logic [4:0]        out_day_of_month,
  input  logic [3:0]        out_month,
  input  logic [11:0]       out_year,
  input  logic [2:0]        out_weekday,
  output int unsigned       fail_count,
  output int unsigned       pending,
  output int unsigned       checked
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [5:0]  second;
    logic [5:0]  minute;
    logic [4:0]  hour;
    logic [4:0]  day_of_month;
    logic [3:0]  month;
    logic [11:0] year;
    logic [2:0]  weekday;
  } utc_date_t;

  localparam int unsigned DAYS_IN_MONTH [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  utc_date_t pending_dates [$];

  function automatic bit is_leap(input int unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic utc_date_t calendar_of(input logic [31:0] stamp);
    utc_date_t   d;
    int unsigned secs;
    int unsigned days;
    int unsigned yr;
    int unsigned mon;
    int unsigned mlen;
    secs = stamp;
    days = secs / 86400;
    d.second  = 6'(secs % 60);
    d.minute  = 6'((secs / 60) % 60);
    d.hour    = 5'((secs / 3600) % 24);
    d.weekday = 3'((4 + days) % 7 + 1);
    yr = 1970;
    while (days >= (is_leap(yr) ? 366 : 365)) begin
      days -= is_leap(yr) ? 366 : 365;
      yr++;
    end
    // a remainder equal to the month length rolls over to the next month
    mon = 0;
    while (mon < 11) begin
      mlen = DAYS_IN_MONTH[mon] + ((mon == 1 && is_leap(yr)) ? 1 : 0);
      if (days < mlen) break;
      days -= mlen;
      mon++;
    end
    d.day_of_month = 5'(days + 1);
    d.month        = 4'(mon + 1);
    d.year         = 12'(yr);
    return d;
  endfunction

  function automatic bit field_ok(input string name, input int unsigned exp_v,
                                  input int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
      return 1'b0;
    end
    return 1'b1;
  endfunction

  always @(posedge clk) begin : watch
    utc_date_t want;
    bit        ok;
    if (rst_n) begin
      // pop before push so a spurious result never pairs with a new stamp
      if (out_valid && out_ready) begin
        if (pending_dates.size() == 0) begin
          $error("result transfer with no date pending");
          fail_count++;
        end else begin
          want = pending_dates.pop_front();
          ok = 1'b1;
          ok &= field_ok("second",       want.second,       out_second);
          ok &= field_ok("minute",       want.minute,       out_minute);
          ok &= field_ok("hour",         want.hour,         out_hour);
          ok &= field_ok("day_of_month", want.day_of_month, out_day_of_month);
          ok &= field_ok("month",        want.month,        out_month);
          ok &= field_ok("year",         want.year,         out_year);
          ok &= field_ok("weekday",      want.weekday,      out_weekday);
          if (!ok) fail_count++;
          checked++;
        end
      end
      if (in_valid && in_ready) pending_dates.push_back(calendar_of(in_epoch_seconds));
      pending = pending_dates.size();
    end else begin
      pending_dates.delete();
      fail_count = 0;
      pending    = 0;
      checked    = 0;
    end
  end

endmodule

/* sim/epoch_seconds_to_calendar_unit_tb.sv */
// testbench top: drives timestamps and result back-pressure, reports the verdict
module epoch_seconds_to_calendar_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RANDOM_STAMPS = 1450;
  localparam int unsigned CYCLE_LIMIT   = 1200000;
  localparam int unsigned HOLD_CYCLES   = 1000;
  localparam int unsigned DRAIN_CYCLES  = 200;
  localparam int unsigned DAYS_PER_MONTH [12] = '{31, 28, 31, 30, 31, 30,
                                                  31, 31, 30, 31, 30, 31};

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [31:0] in_epoch_seconds;
  logic        out_valid;
  logic        out_ready;
  logic [5:0]  out_second;
  logic [5:0]  out_minute;
  logic [4:0]  out_hour;
  logic [4:0]  out_day_of_month;
  logic [3:0]  out_month;
  logic [11:0] out_year;
  logic [2:0]  out_weekday;

  logic        quiet;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned checked;
  int unsigned cycles;
  int unsigned offered;
  int unsigned held;

  epoch_seconds_to_calendar_unit u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_epoch_seconds (in_epoch_seconds),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_second       (out_second),
    .out_minute       (out_minute),
    .out_hour         (out_hour),
    .out_day_of_month (out_day_of_month),
    .out_month        (out_month),
    .out_year         (out_year),
    .out_weekday      (out_weekday)
  );

  esc_checker u_chk (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_epoch_seconds (in_epoch_seconds),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_second       (out_second),
    .out_minute       (out_minute),
    .out_hour         (out_hour),
    .out_day_of_month (out_day_of_month),
    .out_month        (out_month),
    .out_year         (out_year),
    .out_weekday      (out_weekday),
    .fail_count       (fail_count),
    .pending          (pending),
    .checked          (checked)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  function automatic bit leap(input int y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  // seconds at midnight starting the given date, 64 bits so 2106 can overflow safely
  function automatic longint midnight_of(input int y, input int m, input int d);
    longint days;
    days = d - 1;
    for (int yy = 1970; yy < y; yy++) days += leap(yy) ? 366 : 365;
    for (int mm = 0; mm < m - 1; mm++)
      days += DAYS_PER_MONTH[mm] + ((mm == 1 && leap(y)) ? 1 : 0);
    return days * 86400;
  endfunction

  task automatic offer_stamp(input logic [31:0] stamp);
    while (!quiet && $urandom_range(99) < 22) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid         <= 1'b1;
    in_epoch_seconds <= stamp;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    offered++;
    @(negedge clk);
  endtask

  // random stamp, biased toward month and year rollovers
  function automatic logic [31:0] pick_stamp();
    int unsigned sel;
    longint      start;
    longint      v;
    sel = $urandom_range(99);
    if (sel < 40) return $urandom;
    if (sel < 55) return $urandom_range(0, 400 * 86400);
    start = midnight_of($urandom_range(1970, 2106), $urandom_range(1, 12), 1);
    case ($urandom_range(3))
      0:       v = start - 1;
      1:       v = start;
      2:       v = start - 1 - $urandom_range(0, 86399);
      default: v = start + $urandom_range(0, 86399);
    endcase
    if (v < 0 || v > 64'hFFFF_FFFF) return $urandom;
    return 32'(v);
  endfunction

  // result side: random stalls, one long hold-off to back the block up
  initial begin : receiver
    int unsigned seen;
    int unsigned hold;
    bit          hold_done;
    seen      = 0;
    hold      = 0;
    hold_done = 1'b0;
    held      = 0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) seen++;
      @(negedge clk);
      if (!hold_done && seen >= 60) begin
        hold      = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold > 0) begin
        out_ready <= 1'b0;
        hold--;
        held++;
      end else if (quiet) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(99) >= 22);
      end
    end
  end

  initial begin : watchdog
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin : stimulus
    logic [31:0] directed [$];
    in_valid         = 1'b0;
    in_epoch_seconds = '0;
    quiet            = 1'b0;
    offered          = 0;
    rst_n            = 1'b0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // time-of-day rollovers, month ends, leap days and the non-leap century
    directed = {32'd0, 32'd59, 32'd60, 32'd3599, 32'd3600, 32'd86399, 32'd86400,
                32'(midnight_of(1970, 2, 1) - 1), 32'(midnight_of(1970, 2, 1)),
                32'(midnight_of(1972, 2, 29)), 32'(midnight_of(1972, 3, 1) - 1),
                32'(midnight_of(1972, 3, 1)),
                32'(midnight_of(1973, 1, 1) - 1), 32'(midnight_of(1973, 1, 1)),
                32'(midnight_of(2000, 3, 1) - 1), 32'(midnight_of(2000, 3, 1)),
                32'(midnight_of(2100, 3, 1) - 1), 32'(midnight_of(2100, 3, 1)),
                32'(midnight_of(2101, 1, 1) - 1),
                32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFE, 32'hFFFF_FFFF};
    foreach (directed[i]) offer_stamp(directed[i]);

    for (int i = 0; i < RANDOM_STAMPS; i++) begin
      quiet <= (i >= 500 && i < 700);
      offer_stamp(pick_stamp());
    end
    in_valid <= 1'b0;
    quiet    <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("converted %0d timestamps (%0d directed), %0d results compared",
             offered, directed.size(), checked);
    $display("one result stall of %0d cycles backed up the input, %0d cycles in all",
             held, cycles);
    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
